/* sv/qslerp_pkg.sv */
// Types, constants and small helpers for the quaternion slerp core.
// Used by quaternion_slerp_core; depends on nothing.
package qslerp_pkg;

  // Fraction bits of the internal angle, sine and weight words.
  localparam int WB = 30;
  // CORDIC gain compensation, 0.60725.. in Q30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_W = 34'sd1073741824;
  localparam logic signed [17:0] OUT_MAX = 18'sd131071;
  localparam logic signed [17:0] OUT_MIN = -18'sd131072;

  typedef enum logic [1:0] {
    PATH_COPY      = 2'd0,
    PATH_LINEAR    = 2'd1,
    PATH_SPHERICAL = 2'd2
  } path_t;

  // Per-word side data that travels down the pipeline.
  typedef struct packed {
    logic [3:0][18:0] q;    // first quaternion, negated when the dot product is negative
    logic [3:0][17:0] r;
    logic [16:0]      t;    // blend time clamped to one
    path_t            path;
    logic [29:0]      d30;  // |dot| in Q30
    logic [30:0]      s30;  // sin(omega) in Q30
  } side_t;

  // atan(2^-i) in Q30, rounded to nearest.
  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      default: v = 32'(64'd1 << (WB - i));
    endcase
    return v;
  endfunction

  function automatic logic [17:0] sat18(input logic signed [51:0] v);
    logic [17:0] o;
    if (v > 52'(OUT_MAX))      o = OUT_MAX;
    else if (v < 52'(OUT_MIN)) o = OUT_MIN;
    else                       o = v[17:0];
    return o;
  endfunction

endpackage

/* sv/quaternion_slerp_core.sv */
// Quaternion spherical linear interpolation, fully pipelined fixed point.
// Depends on qslerp_pkg (types, CORDIC table, saturation).
//
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    in_tdata: q_w q_x q_y q_z r_w r_x r_y r_z blend_time
// out_      out  out_tvalid/out_tready  out_tdata: out_w..out_z, out_tuser: path_taken
// cfg_      in   cfg_valid/cfg_ready    cfg_data: small_angle_limit
//
// One word enters per cycle while the output is not stalled; the depth is set by the 31-step square
// root, the two 30-step CORDIC chains and the 32-step divider, one bit per stage.
// Reset (synchronous, rst_n low) empties the pipeline and loads the limit with 66.
// A stall on the output freezes every stage at once; in_tready is low meanwhile.
// Configuration is always ready; the limit is read as a word leaves the square root,
// so write it only while no word is in flight.
module quaternion_slerp_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // q_w[17:0] q_x q_y q_z r_w r_x r_y r_z blend_time[160:144], zero pad to 168
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_w[17:0] out_x[35:18] out_y[53:36] out_z[71:54]
  output logic [71:0]  out_tdata,
  // path_taken[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int WB  = qslerp_pkg::WB;
  localparam int SQN = WB + 1;
  localparam int DVN = 32;
  localparam int LAT = 3 + (SQN + 1) + (WB + 1) + 1 + (WB + 1) + (DVN + 1) + 3;
  localparam int SHR = (2 * FRAC_BITS >= WB) ? 2 * FRAC_BITS - WB : 0;
  localparam int SHL = (2 * FRAC_BITS < WB) ? WB - 2 * FRAC_BITS : 0;
  localparam logic [63:0] DOT_ONE  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [30:0] ONE      = 31'd1 << FRAC_BITS;
  localparam logic [61:0] ANG_HALF = 62'd1 << (FRAC_BITS - 1);
  localparam logic signed [51:0] LIN_HALF = 52'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [51:0] SPH_HALF = 52'sd1 <<< (WB - 1);

  logic adv;
  logic [LAT-1:0] vld_r;
  logic [15:0] limit_r;

  assign adv        = !vld_r[LAT-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAT-1];
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      limit_r <= 16'd66;
    end else begin
      if (adv) vld_r <= {vld_r[LAT-2:0], in_tvalid};
      if (cfg_valid) limit_r <= cfg_data;
    end
  end

  // ---------------- stage 1: unpack, products, clamp time
  logic [3:0][17:0] in_q, in_r;
  logic [16:0] in_t;
  logic [3:0][35:0] prod_r;
  qslerp_pkg::side_t s1_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_q[i] = in_tdata[18*i +: 18];
      in_r[i] = in_tdata[72 + 18*i +: 18];
    end
    in_t = in_tdata[160:144];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= 36'($signed(in_q[i]) * $signed(in_r[i]));
        s1_r.q[i] <= {in_q[i][17], in_q[i]};
        s1_r.r[i] <= in_r[i];
      end
      s1_r.t    <= ({14'd0, in_t} > ONE) ? ONE[16:0] : in_t;
      s1_r.path <= qslerp_pkg::PATH_COPY;
      s1_r.d30  <= '0;
      s1_r.s30  <= '0;
    end
  end

  // ---------------- stage 2: dot sum, fold sign, copy test, rescale
  logic signed [37:0] dot;
  logic [37:0] dabs;
  qslerp_pkg::side_t s2_nxt, s2_r;

  always_comb begin
    dot = 38'($signed(prod_r[0])) + 38'($signed(prod_r[1]))
        + 38'($signed(prod_r[2])) + 38'($signed(prod_r[3]));
    dabs   = dot[37] ? 38'(-dot) : dot;
    s2_nxt = s1_r;
    if (dot[37]) begin
      for (int i = 0; i < 4; i++) s2_nxt.q[i] = 19'(-$signed(s1_r.q[i]));
    end
    s2_nxt.path = ({26'd0, dabs} >= DOT_ONE) ? qslerp_pkg::PATH_COPY
                                             : qslerp_pkg::PATH_LINEAR;
    s2_nxt.d30  = 30'((64'(dabs) >> SHR) << SHL);
  end

  always_ff @(posedge clk) begin
    if (adv) s2_r <= s2_nxt;
  end

  // ---------------- stage 3: square of d
  logic [59:0] dsq_r;
  qslerp_pkg::side_t s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dsq_r <= 60'(s2_r.d30 * s2_r.d30);
      s3_r  <= s2_r;
    end
  end

  // ---------------- square root, one result bit per stage (entry 0 loads 1 - d^2)
  logic [60:0] sq_rem_r  [SQN+1];
  logic [30:0] sq_root_r [SQN+1];
  qslerp_pkg::side_t sq_side_r [SQN+1];
  logic [60:0] sq_rem_nxt  [SQN+1];
  logic [30:0] sq_root_nxt [SQN+1];

  always_comb begin
    logic [62:0] trial;
    sq_rem_nxt[0]  = (61'd1 << 60) - 61'(dsq_r);
    sq_root_nxt[0] = '0;
    for (int j = 1; j <= SQN; j++) begin
      trial = (63'(sq_root_r[j-1]) << (SQN - j + 1)) + (63'd1 << (2 * (SQN - j)));
      if ({2'b00, sq_rem_r[j-1]} >= trial) begin
        sq_rem_nxt[j]  = 61'({2'b00, sq_rem_r[j-1]} - trial);
        sq_root_nxt[j] = sq_root_r[j-1] | (31'd1 << (SQN - j));
      end else begin
        sq_rem_nxt[j]  = sq_rem_r[j-1];
        sq_root_nxt[j] = sq_root_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j <= SQN; j++) begin
        sq_rem_r[j]  <= sq_rem_nxt[j];
        sq_root_r[j] <= sq_root_nxt[j];
        sq_side_r[j] <= (j == 0) ? s3_r : sq_side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // ---------------- vectoring CORDIC for omega (entry 0 picks the path)
  logic signed [33:0] at_x_r [WB+1];
  logic signed [33:0] at_y_r [WB+1];
  logic signed [33:0] at_z_r [WB+1];
  qslerp_pkg::side_t at_side_r [WB+1];
  logic signed [33:0] at_x_nxt [WB+1];
  logic signed [33:0] at_y_nxt [WB+1];
  logic signed [33:0] at_z_nxt [WB+1];
  qslerp_pkg::side_t at0_side;
  logic [35:0] lim30;

  always_comb begin
    logic signed [33:0] ang;
    lim30    = 36'(limit_r) << (WB - FRAC_BITS);
    at0_side = sq_side_r[SQN];
    at0_side.s30 = sq_root_r[SQN];
    if (at0_side.path != qslerp_pkg::PATH_COPY) begin
      at0_side.path = ((36'(sq_root_r[SQN]) < lim30) || (sq_root_r[SQN] == '0))
                    ? qslerp_pkg::PATH_LINEAR : qslerp_pkg::PATH_SPHERICAL;
    end
    at_x_nxt[0] = $signed(34'(sq_side_r[SQN].d30));
    at_y_nxt[0] = $signed(34'(sq_root_r[SQN]));
    at_z_nxt[0] = '0;
    for (int i = 1; i <= WB; i++) begin
      ang = $signed({2'b00, qslerp_pkg::atan_tab(i - 1)});
      if (at_y_r[i-1] > 0) begin
        at_x_nxt[i] = at_x_r[i-1] + (at_y_r[i-1] >>> (i - 1));
        at_y_nxt[i] = at_y_r[i-1] - (at_x_r[i-1] >>> (i - 1));
        at_z_nxt[i] = at_z_r[i-1] + ang;
      end else begin
        at_x_nxt[i] = at_x_r[i-1] - (at_y_r[i-1] >>> (i - 1));
        at_y_nxt[i] = at_y_r[i-1] + (at_x_r[i-1] >>> (i - 1));
        at_z_nxt[i] = at_z_r[i-1] - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= WB; i++) begin
        at_x_r[i]    <= at_x_nxt[i];
        at_y_r[i]    <= at_y_nxt[i];
        at_z_r[i]    <= at_z_nxt[i];
        at_side_r[i] <= (i == 0) ? at0_side : at_side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // ---------------- stage 6: clamp omega, partial angle products
  logic [30:0] omega;
  logic [30:0] t31;
  logic [61:0] pa_r, pb_r;
  qslerp_pkg::side_t s6_r;

  always_comb begin
    omega = at_z_r[WB][33] ? 31'd0 : at_z_r[WB][30:0];
    t31   = 31'(at_side_r[WB].t);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= 62'((ONE - t31) * omega);
      pb_r <= 62'(t31 * omega);
      s6_r <= at_side_r[WB];
    end
  end

  // ---------------- rotation CORDIC for both sines, two lanes (entry 0 rounds the angles)
  logic signed [33:0] sn_x_r [WB+1][2];
  logic signed [33:0] sn_y_r [WB+1][2];
  logic signed [33:0] sn_z_r [WB+1][2];
  qslerp_pkg::side_t sn_side_r [WB+1];
  logic signed [33:0] sn_x_nxt [WB+1][2];
  logic signed [33:0] sn_y_nxt [WB+1][2];
  logic signed [33:0] sn_z_nxt [WB+1][2];

  always_comb begin
    logic signed [33:0] ang;
    for (int l = 0; l < 2; l++) begin
      sn_x_nxt[0][l] = qslerp_pkg::CORDIC_GAIN;
      sn_y_nxt[0][l] = '0;
    end
    sn_z_nxt[0][0] = $signed(34'((pa_r + ANG_HALF) >> FRAC_BITS));
    sn_z_nxt[0][1] = $signed(34'((pb_r + ANG_HALF) >> FRAC_BITS));
    for (int i = 1; i <= WB; i++) begin
      ang = $signed({2'b00, qslerp_pkg::atan_tab(i - 1)});
      for (int l = 0; l < 2; l++) begin
        if (!sn_z_r[i-1][l][33]) begin
          sn_x_nxt[i][l] = sn_x_r[i-1][l] - (sn_y_r[i-1][l] >>> (i - 1));
          sn_y_nxt[i][l] = sn_y_r[i-1][l] + (sn_x_r[i-1][l] >>> (i - 1));
          sn_z_nxt[i][l] = sn_z_r[i-1][l] - ang;
        end else begin
          sn_x_nxt[i][l] = sn_x_r[i-1][l] + (sn_y_r[i-1][l] >>> (i - 1));
          sn_y_nxt[i][l] = sn_y_r[i-1][l] - (sn_x_r[i-1][l] >>> (i - 1));
          sn_z_nxt[i][l] = sn_z_r[i-1][l] + ang;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= WB; i++) begin
        for (int l = 0; l < 2; l++) begin
          sn_x_r[i][l] <= sn_x_nxt[i][l];
          sn_y_r[i][l] <= sn_y_nxt[i][l];
          sn_z_r[i][l] <= sn_z_nxt[i][l];
        end
        sn_side_r[i] <= (i == 0) ? s6_r : sn_side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // ---------------- weight dividers, one quotient bit per stage (entry 0 clamps the sines)
  logic [31:0] dv_rem_r [DVN+1][2];
  logic [31:0] dv_lo_r  [DVN+1][2];
  logic [31:0] dv_quo_r [DVN+1][2];
  qslerp_pkg::side_t dv_side_r [DVN+1];
  logic [31:0] dv_rem_nxt [DVN+1][2];
  logic [31:0] dv_lo_nxt  [DVN+1][2];
  logic [31:0] dv_quo_nxt [DVN+1][2];

  always_comb begin
    logic signed [33:0] y;
    logic [30:0] sn;
    logic [31:0] rem2;
    for (int l = 0; l < 2; l++) begin
      y = sn_y_r[WB][l];
      if (y[33])                        sn = '0;
      else if (y > qslerp_pkg::ONE_W)   sn = 31'(qslerp_pkg::ONE_W);
      else                              sn = y[30:0];
      // numerator is sn << 30: high part preloads the remainder
      dv_rem_nxt[0][l] = 32'(sn >> 2);
      dv_lo_nxt[0][l]  = {sn[1:0], 30'd0};
      dv_quo_nxt[0][l] = '0;
      for (int j = 1; j <= DVN; j++) begin
        rem2 = {dv_rem_r[j-1][l][30:0], dv_lo_r[j-1][l][31]};
        dv_lo_nxt[j][l] = {dv_lo_r[j-1][l][30:0], 1'b0};
        if (rem2 >= {1'b0, dv_side_r[j-1].s30}) begin
          dv_rem_nxt[j][l] = rem2 - {1'b0, dv_side_r[j-1].s30};
          dv_quo_nxt[j][l] = {dv_quo_r[j-1][l][30:0], 1'b1};
        end else begin
          dv_rem_nxt[j][l] = rem2;
          dv_quo_nxt[j][l] = {dv_quo_r[j-1][l][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j <= DVN; j++) begin
        for (int l = 0; l < 2; l++) begin
          dv_rem_r[j][l] <= dv_rem_nxt[j][l];
          dv_lo_r[j][l]  <= dv_lo_nxt[j][l];
          dv_quo_r[j][l] <= dv_quo_nxt[j][l];
        end
        dv_side_r[j] <= (j == 0) ? sn_side_r[WB] : dv_side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // ---------------- stage 9: split-weight and linear products
  logic [3:0][35:0] qlo_r, qhi_r, rlo_r, rhi_r;
  logic [3:0][51:0] lq_r, lr_r;
  qslerp_pkg::side_t s9_r;
  logic [31:0] wa, wb;
  logic [30:0] t9;

  always_comb begin
    wa = dv_quo_r[DVN][0];
    wb = dv_quo_r[DVN][1];
    t9 = 31'(dv_side_r[DVN].t);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        qlo_r[i] <= 36'($signed(dv_side_r[DVN].q[i]) * $signed({1'b0, wa[15:0]}));
        qhi_r[i] <= 36'($signed(dv_side_r[DVN].q[i]) * $signed({1'b0, wa[31:16]}));
        rlo_r[i] <= 36'($signed(dv_side_r[DVN].r[i]) * $signed({1'b0, wb[15:0]}));
        rhi_r[i] <= 36'($signed(dv_side_r[DVN].r[i]) * $signed({1'b0, wb[31:16]}));
        lq_r[i]  <= 52'($signed({1'b0, ONE - t9}) * $signed(dv_side_r[DVN].q[i]));
        lr_r[i]  <= 52'($signed({1'b0, t9}) * $signed(dv_side_r[DVN].r[i]));
      end
      s9_r <= dv_side_r[DVN];
    end
  end

  // ---------------- stage 10: assemble the sums
  logic [3:0][51:0] pq_r, pr_r, lin_r;
  qslerp_pkg::side_t s10_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pq_r[i]  <= (52'($signed(qhi_r[i])) <<< 16) + 52'($signed(qlo_r[i]));
        pr_r[i]  <= (52'($signed(rhi_r[i])) <<< 16) + 52'($signed(rlo_r[i]));
        lin_r[i] <= $signed(lq_r[i]) + $signed(lr_r[i]);
      end
      s10_r <= s9_r;
    end
  end

  // ---------------- stage 11: round, select, saturate into the output register
  logic [3:0][17:0] res_nxt, res_r;
  qslerp_pkg::path_t path_r;

  always_comb begin
    logic signed [51:0] v;
    for (int i = 0; i < 4; i++) begin
      unique case (s10_r.path)
        qslerp_pkg::PATH_LINEAR:
          v = ($signed(lin_r[i]) + LIN_HALF) >>> FRAC_BITS;
        qslerp_pkg::PATH_SPHERICAL:
          v = ($signed(pq_r[i]) + $signed(pr_r[i]) + SPH_HALF) >>> WB;
        default:
          v = 52'($signed(s10_r.q[i]));
      endcase
      res_nxt[i] = qslerp_pkg::sat18(v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      path_r <= s10_r.path;
    end
  end

  assign out_tdata = res_r;
  assign out_tuser = path_r;

endmodule

/* sv/qslerp_checker.sv */
// Port-level checks for quaternion_slerp_core, attached by bind.
// Depends only on the top level's ports.
module qslerp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // the input side stalls exactly when a result is held back
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind quaternion_slerp_core qslerp_checker u_qslerp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
